FILE: design/pls_pkg.sv
// Package for the positional list store: sizes, command and status codes,
// and the controller-to-datapath command struct. No dependencies.
`default_nettype none

package pls_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 5;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic exec;
	} dp_cmd_t;

endpackage

`default_nettype wire

FILE: design/positional_list_store.sv
// Channel   Dir  tdata fields (low bit first)
// s_axis    in   cmd[1:0] position[6:2] data_in[38:7] zero[39]
// m_axis    out  status[1:0] data_out[33:2] count[38:34] is_empty[39]
// One command per cycle while m_tready is high: the cells shift the entries
// past the position on accept; the result is registered, shown next cycle.
// A new command is taken while a result waits if that result leaves the same cycle.
// Reset (arst_n low) empties the list; slot contents are not cleared.
// Top level; depends on pls_pkg, pls_ctrl and pls_dp.
`default_nettype none

module positional_list_store
	import pls_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // cmd, position, data_in
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata   // status, data_out, count, is_empty
);

	dp_cmd_t           dp_cmd;
	logic [STAT_W-1:0] status;
	logic [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]  count;
	logic              is_empty;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_cmd   (dp_cmd)
	);

	pls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.dp_cmd   (dp_cmd),
		.cmd      (s_tdata[1:0]),
		.position (s_tdata[6:2]),
		.data_in  (s_tdata[38:7]),
		.status   (status),
		.data_out (data_out),
		.count    (count),
		.is_empty (is_empty)
	);

	assign m_tdata = {is_empty, count, data_out, status};

endmodule

`default_nettype wire

FILE: design/pls_ctrl.sv
// Handshake controller of the positional list store.
// Depends on pls_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module pls_ctrl
	import pls_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output dp_cmd_t      dp_cmd
);

	typedef enum logic {
		IDLE,
		HOLD
	} state_t;

	state_t state_q;

	assign m_tvalid    = (state_q == HOLD);
	assign s_tready    = (state_q == IDLE) || m_tready;
	assign dp_cmd.exec = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (dp_cmd.exec) state_q <= HOLD;
				end
				HOLD: begin
					if (dp_cmd.exec) state_q <= HOLD;
					else if (m_tready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec |=> m_tvalid)
		else $error("accepted command produced no result");

	a_taken_no_new: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !dp_cmd.exec) |=> !m_tvalid)
		else $error("result repeated after transfer");

endmodule

`default_nettype wire

FILE: design/pls_dp.sv
// Datapath of the positional list store: slot cell chain, entry count,
// range checks and output register. Depends on pls_pkg.
`default_nettype none

module pls_dp
	import pls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           dp_cmd,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [DATA_W-1:0] data_in,
	output logic [STAT_W-1:0]      status,
	output logic [DATA_W-1:0]      data_out,
	output logic [CNT_W-1:0]       count,
	output logic                   is_empty
);

	logic [DATA_W-1:0] slots_q [CAPACITY];
	logic [CNT_W-1:0]  used_q;

	logic [CNT_W:0]    pos_x;
	logic [CNT_W:0]    used_x;
	logic [POS_W-1:0]  pos_m1;
	logic [IDX_W-1:0]  idx;
	logic              pos_ok;
	logic              ins_ok;
	logic              is_full;
	logic              do_ins;
	logic              do_rem;
	logic              do_wr;
	status_t           stat_c;
	logic [DATA_W-1:0] dout_c;
	logic [CNT_W-1:0]  used_d;

	assign pos_x   = {1'b0, position};
	assign used_x  = {1'b0, used_q};
	assign pos_m1  = position - POS_W'(1);
	assign idx     = pos_m1[IDX_W-1:0];
	assign pos_ok  = (position != '0) && (pos_x <= used_x);
	assign ins_ok  = (position != '0) && (pos_x <= used_x + (CNT_W+1)'(1));
	assign is_full = (used_x >= (CNT_W+1)'(CAPACITY));

	always_comb begin
		stat_c = ST_DONE;
		dout_c = '0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		do_wr  = 1'b0;
		used_d = used_q;
		if (cmd == CMD_INSERT) begin
			if (!ins_ok) begin
				stat_c = ST_RANGE;
			end else if (is_full) begin
				stat_c = ST_FULL;
			end else begin
				do_ins = 1'b1;
				used_d = used_q + CNT_W'(1);
			end
		end else if (!pos_ok) begin
			stat_c = ST_RANGE;
		end else begin
			case (cmd)
				CMD_READ: dout_c = slots_q[idx];
				CMD_WRITE: do_wr = 1'b1;
				CMD_REMOVE: begin
					dout_c = slots_q[idx];
					do_rem = 1'b1;
					used_d = used_q - CNT_W'(1);
				end
				default: stat_c = ST_DONE;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W:0] I_X = (CNT_W+1)'(i);
		logic [IDX_W:0] idx_x;
		assign idx_x = {1'b0, idx};
		always_ff @(posedge clk) begin
			if (dp_cmd.exec) begin
				if ((do_ins || do_wr) && (idx_x == I_X[IDX_W:0])) begin
					slots_q[i] <= data_in;
				end else if (do_ins && (idx_x < I_X[IDX_W:0]) && (I_X <= used_x)) begin
					if (i > 0) slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
				end else if (do_rem && (idx_x <= I_X[IDX_W:0])
						&& (I_X + (CNT_W+1)'(1) < used_x)) begin
					if (i < CAPACITY - 1)
						slots_q[i] <= slots_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (dp_cmd.exec) begin
			used_q <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			status   <= stat_c;
			data_out <= dout_c;
			count    <= used_d;
			is_empty <= (used_d == '0);
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_x <= (CNT_W+1)'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.exec && do_ins) |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!dp_cmd.exec |=> $stable(used_q))
		else $error("entry count changed without a command");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for positional_list_store: streams read, overwrite, insert and
// remove commands, predicts each result from a shadow list and checks it.
// Depends on pls_pkg and the positional_list_store RTL.
`timescale 1ns / 100ps

module testbench;
	import pls_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		status_t            status;
		logic [DATA_W-1:0]  data;
		logic [CNT_W-1:0]   count;
		logic               empty;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// shadow copy of the list
	logic [DATA_W-1:0] shadow_list [CAPACITY];
	int                shadow_len = 0;

	list_result_t      pending_results [$];
	list_result_t      got;
	int                mismatch_count = 0;
	int                cycle_count = 0;
	int                status_tally [3] = '{0, 0, 0};
	int                longest_list = 0;
	bit                no_gaps = 1'b0;
	int                hold_request = 0;
	int                hold_served = 0;
	int                hold_left = 0;

	positional_list_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic list_result_t predict_cmd(cmd_t op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] value);
		list_result_t r;
		int p;
		p = pos;
		r.status = ST_DONE;
		r.data = '0;
		if (op == CMD_INSERT) begin
			if (p < 1 || p > shadow_len + 1) begin
				r.status = ST_RANGE;
			end else if (shadow_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				for (int i = shadow_len; i > p - 1; i--)
					shadow_list[i] = shadow_list[i-1];
				shadow_list[p-1] = value;
				shadow_len++;
			end
		end else if (p < 1 || p > shadow_len) begin
			r.status = ST_RANGE;
		end else if (op == CMD_WRITE) begin
			shadow_list[p-1] = value;
		end else begin
			r.data = shadow_list[p-1];
			if (op == CMD_REMOVE) begin
				for (int i = p - 1; i + 1 < shadow_len; i++)
					shadow_list[i] = shadow_list[i+1];
				shadow_len--;
			end
		end
		r.count = shadow_len[CNT_W-1:0];
		r.empty = (shadow_len == 0);
		return r;
	endfunction

	// one command transfer; entered and left right after a rising edge
	task automatic send_cmd(input cmd_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] value);
		list_result_t r;
		while (!no_gaps && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, value, pos, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_cmd(op, pos, value);
		pending_results.push_back(r);
		status_tally[r.status]++;
		if (shadow_len > longest_list)
			longest_list = shadow_len;
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(cmd_t op);
		int limit;
		limit = (op == CMD_INSERT) ? shadow_len + 1 : shadow_len;
		if (limit == 0 || $urandom_range(0, 99) < 25)
			return POS_W'($urandom_range(0, 31));
		return POS_W'($urandom_range(1, limit));
	endfunction

	function automatic cmd_t pick_cmd(int grow_pct);
		int u;
		u = $urandom_range(0, 99);
		if (u < 20)
			return CMD_READ;
		if (u < 40)
			return CMD_WRITE;
		return ($urandom_range(0, 99) < grow_pct) ? CMD_INSERT : CMD_REMOVE;
	endfunction

	task automatic send_random(input int n, input int grow_pct);
		cmd_t op;
		for (int k = 0; k < n; k++) begin
			op = pick_cmd(grow_pct);
			send_cmd(op, pick_position(op), $urandom());
		end
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				mismatch_count++;
			end else begin
				got = pending_results.pop_front();
				if (m_tdata[1:0] != got.status) begin
					$error("status: expected %0d, got %0d", got.status, m_tdata[1:0]);
					mismatch_count++;
				end
				if (m_tdata[33:2] != got.data) begin
					$error("data_out: expected %h, got %h", got.data, m_tdata[33:2]);
					mismatch_count++;
				end
				if (m_tdata[38:34] != got.count) begin
					$error("count: expected %0d, got %0d", got.count, m_tdata[38:34]);
					mismatch_count++;
				end
				if (m_tdata[39] != got.empty) begin
					$error("is_empty: expected %0d, got %0d", got.empty, m_tdata[39]);
					mismatch_count++;
				end
			end
		end
	end

	// result side ready, with random stalls and long hold-offs on request
	always @(posedge clk) begin
		if (hold_request != hold_served) begin
			hold_served = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 19);
		end
	end

	task automatic test_directed();
		send_cmd(CMD_READ,   5'd1,  32'h1234_5678);
		send_cmd(CMD_WRITE,  5'd1,  32'hdead_beef);
		send_cmd(CMD_REMOVE, 5'd1,  32'h0);
		send_cmd(CMD_READ,   5'd0,  32'h0);
		send_cmd(CMD_INSERT, 5'd0,  32'h1);
		send_cmd(CMD_INSERT, 5'd2,  32'h2);
		send_cmd(CMD_INSERT, 5'd1,  32'h8000_0000);
		send_cmd(CMD_INSERT, 5'd2,  32'h7fff_ffff);
		send_cmd(CMD_INSERT, 5'd1,  32'hffff_ffff);
		send_cmd(CMD_INSERT, 5'd4,  32'h0000_0000);
		send_cmd(CMD_INSERT, 5'd6,  32'h3);
		send_cmd(CMD_INSERT, 5'd31, 32'h4);
		for (int p = 1; p <= 5; p++)
			send_cmd(CMD_READ, POS_W'(p), 32'h0);
		send_cmd(CMD_WRITE,  5'd2,  32'h5a5a_5a5a);
		send_cmd(CMD_READ,   5'd2,  32'h0);
		send_cmd(CMD_REMOVE, 5'd2,  32'h0);
		send_cmd(CMD_REMOVE, 5'd3,  32'h0);
		send_cmd(CMD_REMOVE, 5'd1,  32'h0);
		send_cmd(CMD_READ,   5'd31, 32'h0);
		send_cmd(CMD_REMOVE, 5'd1,  32'h0);
		send_cmd(CMD_REMOVE, 5'd1,  32'h0);
	endtask

	task automatic test_full_list();
		while (shadow_len < CAPACITY)
			send_cmd(CMD_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), $urandom());
		send_cmd(CMD_INSERT, 5'd17, $urandom());
		send_cmd(CMD_INSERT, 5'd1,  $urandom());
		send_cmd(CMD_INSERT, 5'd18, $urandom());
		send_cmd(CMD_READ,   5'd16, 32'h0);
		send_cmd(CMD_READ,   5'd17, 32'h0);
		send_cmd(CMD_WRITE,  5'd16, $urandom());
		send_cmd(CMD_REMOVE, 5'd16, 32'h0);
		send_cmd(CMD_INSERT, 5'd16, $urandom());
		while (shadow_len > 0)
			send_cmd(CMD_REMOVE, POS_W'($urandom_range(1, shadow_len)), 32'h0);
		send_cmd(CMD_REMOVE, 5'd1, 32'h0);
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_request++;
		send_random(40, 60);
		no_gaps = 1'b0;
	endtask

	task automatic test_pause();
		send_random(15, 50);
		wait_results_drained();
		send_random(15, 50);
	endtask

	task automatic test_streaming();
		no_gaps = 1'b1;
		send_random(200, 55);
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 10; phase++)
			send_random(100, (phase % 2 == 0) ? 75 : 25);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_random();
		test_backpressure();
		test_pause();
		test_streaming();
		wait_results_drained();
		repeat (10) @(posedge clk);
		$display("%0d commands: %0d done, %0d out of range, %0d refused as full",
			status_tally[0] + status_tally[1] + status_tally[2],
			status_tally[0], status_tally[1], status_tally[2]);
		$display("list length reached %0d of %0d slots", longest_list, CAPACITY);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/pls_pkg.sv
design/pls_ctrl.sv
design/pls_dp.sv
design/positional_list_store.sv
dv/testbench.sv
